>>> src/utf8s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_pkg
// Shared types, constants and byte classifiers for the UTF-8 text sanitizer.
// ----------------------------------------------------------------------------
package utf8s_pkg;

  // Most results a single input request can produce.
  localparam int unsigned MaxRes = 3;
  // Default depth of the result queue.
  localparam int unsigned FifoDepthDef = 8;

  localparam logic [7:0] ReplByte  = 8'hBF;
  localparam logic [7:0] LeadE2    = 8'hE2;
  localparam logic [7:0] Cont80    = 8'h80;
  localparam logic [7:0] LeadC2    = 8'hC2;
  localparam logic [7:0] NbspA0    = 8'hA0;
  localparam logic [7:0] SpaceChr  = 8'h20;
  localparam logic [7:0] ApostChr  = 8'h27;
  localparam logic [7:0] DquoteChr = 8'h22;
  localparam logic [7:0] DashChr   = 8'h2D;
  localparam logic [7:0] LsquoB    = 8'h98;
  localparam logic [7:0] RsquoB    = 8'h99;
  localparam logic [7:0] LdquoB    = 8'h9C;
  localparam logic [7:0] RdquoB    = 8'h9D;
  localparam logic [7:0] EndashB   = 8'h93;
  localparam logic [7:0] EmdashB   = 8'h94;
  localparam logic [7:0] Lead5Mask = 8'hF8;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_output;
  } out_item_t;

  // Results of one decode step, written into the result queue together.
  typedef struct packed {
    logic [1:0]                cnt;
    out_item_t [MaxRes-1:0]    items;
  } push_t;

  function automatic logic ascii_ok(input logic [7:0] c);
    logic ok;
    case (c) inside
      [8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A],
      8'h2E, 8'h2C, 8'h21, 8'h3F, 8'h3B, 8'h3A, 8'h2D, 8'h5F, 8'h28, 8'h29,
      8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h27, 8'h22, 8'h40, 8'h23, 8'h24, 8'h2F,
      8'h5C, 8'h26, 8'h2B, 8'h3D, 8'h25, 8'h7E, 8'h5E, 8'h20: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  // Sequence length announced by a lead byte; stray bytes count as one.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    if (!b[7]) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & Lead5Mask) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  // Third byte of an E2 80 xx punctuation sequence to its ASCII stand-in.
  function automatic logic [7:0] smart_map(input logic [7:0] b);
    logic [7:0] m;
    case (b)
      LsquoB, RsquoB:   m = ApostChr;
      LdquoB, RdquoB:   m = DquoteChr;
      EndashB, EmdashB: m = DashChr;
      default:          m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

>>> src/utf8s_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_decoder
// Lookahead window, skip counter and replacement-run state; decodes one
// registered byte per cycle into zero to three results.
// ----------------------------------------------------------------------------
module utf8s_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  utf8s_pkg::in_item_t item_i,
  output utf8s_pkg::push_t   push_o,
  output logic               clear_o
);
  import utf8s_pkg::*;

  logic [7:0] hold_q [2];
  logic [7:0] hold_d [2];
  logic [1:0] hcnt_q, hcnt_d;
  logic [1:0] skip_q, skip_d;
  logic       run_q, run_d;

  logic       fin;
  logic [7:0] q [5];
  logic [2:0] n;
  logic [1:0] hc;
  logic [2:0] i;
  logic       stop, parked, fallthru, run_w;
  logic [1:0] k;
  out_item_t [MaxRes-1:0] res;
  logic [7:0] b0, m;
  logic [2:0] rem, len, left;
  logic [7:0] dh0, dh1;
  logic [1:0] dcnt, dskip;
  logic       use_drain;
  push_t      push;

  assign fin = item_i.end_of_text;

  // Window walk over held bytes plus the new one: at most three units.
  always_comb begin
    hc = (hcnt_q > 2'd2) ? 2'd2 : hcnt_q;
    for (int e = 0; e < 5; e++) begin
      q[e] = 8'h00;
    end
    case (hc)
      2'd0: begin
        q[0] = item_i.in_byte;
      end
      2'd1: begin
        q[0] = hold_q[0];
        q[1] = item_i.in_byte;
      end
      default: begin
        q[0] = hold_q[0];
        q[1] = hold_q[1];
        q[2] = item_i.in_byte;
      end
    endcase
    n        = {1'b0, hc} + 3'd1;
    i        = 3'd0;
    stop     = 1'b0;
    parked   = 1'b0;
    fallthru = 1'b0;
    run_w    = run_q;
    k        = 2'd0;
    res      = '0;
    b0       = 8'h00;
    m        = 8'h00;
    rem      = 3'd0;
    len      = 3'd0;
    dskip    = 2'd0;
    for (int it = 0; it < MaxRes; it++) begin
      if (!stop && (i < n)) begin
        b0       = q[i];
        rem      = n - i;
        fallthru = 1'b1;
        if (!b0[7]) begin
          fallthru = 1'b0;
          if (ascii_ok(b0)) begin
            res[k] = '{out_byte: b0, byte_valid: 1'b1, end_of_output: 1'b0};
            k      = k + 2'd1;
            run_w  = 1'b0;
          end else if (!run_w) begin
            res[k] = '{out_byte: ReplByte, byte_valid: 1'b1, end_of_output: 1'b0};
            k      = k + 2'd1;
            run_w  = 1'b1;
          end
          i = i + 3'd1;
        end else if (b0 == LeadE2) begin
          if (rem >= 3'd3) begin
            m = smart_map(q[i + 3'd2]);
            if ((q[i + 3'd1] == Cont80) && (m != 8'h00)) begin
              res[k]   = '{out_byte: m, byte_valid: 1'b1, end_of_output: 1'b0};
              k        = k + 2'd1;
              run_w    = 1'b0;
              i        = i + 3'd3;
              fallthru = 1'b0;
            end
          end else if (!fin && ((rem == 3'd1) || (q[i + 3'd1] == Cont80))) begin
            // Could still become a smart quote: wait for more bytes.
            stop     = 1'b1;
            fallthru = 1'b0;
          end
        end else if (b0 == LeadC2) begin
          if (rem >= 3'd2) begin
            if (q[i + 3'd1] == NbspA0) begin
              res[k]   = '{out_byte: SpaceChr, byte_valid: 1'b1, end_of_output: 1'b0};
              k        = k + 2'd1;
              run_w    = 1'b0;
              i        = i + 3'd2;
              fallthru = 1'b0;
            end
          end else if (!fin) begin
            stop     = 1'b1;
            fallthru = 1'b0;
          end
        end
        if (fallthru) begin
          len = lead_len(b0);
          if (!run_w) begin
            res[k] = '{out_byte: ReplByte, byte_valid: 1'b1, end_of_output: 1'b0};
            k      = k + 2'd1;
            run_w  = 1'b1;
          end
          if (len <= rem) begin
            i = i + len;
          end else if (fin) begin
            i = i + 3'd1;
          end else begin
            // The sequence runs into bytes not yet seen; keep skipping them.
            stop   = 1'b1;
            parked = 1'b1;
            dskip  = 2'(len - rem);
          end
        end
      end
    end
    if (parked) begin
      dh0  = q[i + 3'd1];
      dh1  = q[i + 3'd2];
      left = n - i - 3'd1;
    end else begin
      dh0  = q[i];
      dh1  = q[i + 3'd1];
      left = n - i;
    end
    dcnt = (left > 3'd2) ? 2'd2 : left[1:0];
  end

  always_comb begin
    hold_d     = hold_q;
    hcnt_d     = hcnt_q;
    skip_d     = skip_q;
    run_d      = run_q;
    use_drain  = 1'b0;
    push.cnt   = 2'd0;
    push.items = '0;
    if (skip_q != 2'd0) begin
      if (skip_q == 2'd1) begin
        hcnt_d = 2'd0;
        skip_d = 2'd0;
      end else if (!fin) begin
        if (hc < 2'd2) begin
          hold_d[hc[0]] = item_i.in_byte;
          hcnt_d        = hc + 2'd1;
        end else begin
          hcnt_d = hc;
        end
        skip_d = skip_q - 2'd1;
      end else begin
        // Text ended inside a skipped sequence: decode the tail afresh.
        use_drain = 1'b1;
      end
    end else begin
      use_drain = 1'b1;
    end
    if (use_drain) begin
      hold_d[0]  = dh0;
      hold_d[1]  = dh1;
      hcnt_d     = dcnt;
      skip_d     = dskip;
      run_d      = run_w;
      push.cnt   = k;
      push.items = res;
    end
    if (fin) begin
      if (push.cnt == 2'd0) begin
        push.items[0] = '{out_byte: 8'h00, byte_valid: 1'b0, end_of_output: 1'b1};
        push.cnt      = 2'd1;
      end else begin
        push.items[push.cnt - 2'd1].end_of_output = 1'b1;
      end
      hcnt_d = 2'd0;
      skip_d = 2'd0;
      run_d  = 1'b0;
    end
    if (!valid_i) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcnt_q <= 2'd0;
      skip_q <= 2'd0;
      run_q  <= 1'b0;
    end else if (valid_i) begin
      hcnt_q <= hcnt_d;
      skip_q <= skip_d;
      run_q  <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      hold_q <= hold_d;
    end
  end

  assign push_o  = push;
  assign clear_o = (hcnt_q == 2'd0) && (skip_q == 2'd0) && !run_q;

endmodule

>>> src/utf8s_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8s_res_fifo
// Result queue: takes up to three results per cycle, gives one per cycle.
// ----------------------------------------------------------------------------
module utf8s_res_fifo #(
  parameter int unsigned Depth = utf8s_pkg::FifoDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  utf8s_pkg::push_t             push_i,
  input  logic                         pop_i,
  output utf8s_pkg::out_item_t         head_o,
  output logic [$clog2(Depth+1)-1:0]   count_o
);
  import utf8s_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_item_t         mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [PtrW-1:0]   widx [MaxRes];

  // Pointer advance with wrap; the step is always below the depth.
  function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] p,
                                               input logic [1:0] inc);
    logic [PtrW:0] s;
    s = {1'b0, p} + (PtrW + 1)'(inc);
    if (s >= (PtrW + 1)'(Depth)) begin
      s = s - (PtrW + 1)'(Depth);
    end
    return s[PtrW-1:0];
  endfunction

  always_comb begin
    for (int j = 0; j < MaxRes; j++) begin
      widx[j] = wrap_add(wr_ptr_q, 2'(j));
    end
    wr_ptr_d = wrap_add(wr_ptr_q, push_i.cnt);
    rd_ptr_d = pop_i ? wrap_add(rd_ptr_q, 2'd1) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.cnt) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MaxRes; j++) begin
      if (2'(j) < push_i.cnt) begin
        mem_q[widx[j]] <= push_i.items[j];
      end
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

>>> src/utf8_text_sanitizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_sanitizer_top
// Streaming text cleaner: passes plain ASCII, maps UTF-8 smart quotes, dashes
// and no-break space to ASCII, and folds runs of rejected units into 0xBF.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    in_item_i  (in_byte, end_of_text)
//   out      output     out_valid_o / out_ready_i  out_item_o (out_byte, byte_valid,
//                                                             end_of_output)
//
// One byte request is taken per cycle while in_ready_o is high; it is decoded
// the cycle after it is taken, and its results pass through the result queue.
// The decode loop (window state fed back from its own registers) sets the rate.
// Results wait in a FifoDepth-entry queue; in_ready_o stays high while the
// queue has room for the results of the staged and the new request.
// Reset clears the window, skip and run state and empties the queue.
// FifoDepth must be at least 7 for one request per cycle.
// ----------------------------------------------------------------------------
module utf8_text_sanitizer_top #(
  parameter int unsigned FifoDepth = utf8s_pkg::FifoDepthDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  utf8s_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output utf8s_pkg::out_item_t out_item_o
);
  import utf8s_pkg::*;

  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam int unsigned SumW = $clog2(FifoDepth + 2 * MaxRes + 1);

  logic             stage_valid_q;
  in_item_t         stage_item_q;
  push_t            push;
  logic             dec_clear;
  logic [CntW-1:0]  fifo_count;
  logic [SumW-1:0]  need;
  logic             in_accept;
  logic             pop;

  // Room check uses only registered state, so ready never waits on valid.
  assign need       = SumW'(fifo_count) + (stage_valid_q ? SumW'(MaxRes) : SumW'(0))
                      + SumW'(MaxRes);
  assign in_ready_o = (need <= SumW'(FifoDepth));
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_item_q <= in_item_i;
    end
  end

  utf8s_decoder u_decoder (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stage_valid_q),
    .item_i  (stage_item_q),
    .push_o  (push),
    .clear_o (dec_clear)
  );

  utf8s_res_fifo #(
    .Depth (FifoDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (out_item_o),
    .count_o (fifo_count)
  );

  assign out_valid_o = (fifo_count != '0);
  assign pop         = out_valid_o && out_ready_i;

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_count <= CntW'(FifoDepth))
    else $error("result queue overflow");

  a_idle_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_valid_q |-> push.cnt == 2'd0)
    else $error("results pushed without a staged request");

  a_eot_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && stage_item_q.end_of_text) |->
      (push.cnt != 2'd0) && push.items[push.cnt - 2'd1].end_of_output)
    else $error("end of text gave no closing result");

  a_eot_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && stage_item_q.end_of_text) |=> dec_clear)
    else $error("decoder state not cleared after end of text");

endmodule
